/* rtl/i2cm_pkg.sv */
`timescale 1ns / 1ps

package i2cm_pkg;

    // Command and running-operation codes
    typedef enum logic [2:0] {
        OP_IDLE  = 3'd0,
        OP_START = 3'd1,
        OP_STOP  = 3'd2,
        OP_SEND  = 3'd3,
        OP_RECV  = 3'd4,
        OP_SACK  = 3'd5,
        OP_RACK  = 3'd6
    } t_op;

    localparam int unsigned BITS_PER_BYTE = 8;
    localparam int unsigned PHASE_W       = 5;
    localparam int unsigned SLOT_W        = 2;

    // Bit slot positions; on send: drive SDA / raise SCL / lower SCL
    localparam logic [SLOT_W-1:0] SLOT_SDA  = 2'd0;
    localparam logic [SLOT_W-1:0] SLOT_HIGH = 2'd1;
    localparam logic [SLOT_W-1:0] SLOT_LOW  = 2'd2;

    localparam logic [PHASE_W-1:0] LAST_SHORT = 5'd3;
    localparam logic [PHASE_W-1:0] LAST_SACK  = 5'd2;
    localparam logic [PHASE_W-1:0] LAST_SEND  = PHASE_W'(3 * BITS_PER_BYTE - 1);
    localparam logic [PHASE_W-1:0] LAST_RECV  = PHASE_W'(3 * BITS_PER_BYTE);

    // Index of the final phase of each operation
    function automatic logic [PHASE_W-1:0] last_phase(input t_op op);
        logic [PHASE_W-1:0] r;
        case (op)
            OP_SEND: r = LAST_SEND;
            OP_RECV: r = LAST_RECV;
            OP_SACK: r = LAST_SACK;
            default: r = LAST_SHORT;
        endcase
        return r;
    endfunction

endpackage

/* rtl/i2c_master_bit_engine.sv */
`timescale 1ns / 1ps
// The result of an accepted input transaction is registered straight into the output register.
// Throughput: one transaction per cycle; the output register frees as the result is taken,
// so input ready is low only while a result is held and the output side stalls.
// Reset (synchronous, active low): idle, disabled, SCL and SDA released, no result pending.
// Every command phase runs on the tick that carries it, the first on the accepting tick.

module i2c_master_bit_engine
    import i2cm_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,

    // configuration write channel
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic       i_cfg_enabled,

    // phase tick input channel
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [2:0] i_cmd,
    input  logic [7:0] i_data_byte,
    input  logic       i_ack_bit,
    input  logic       i_sda_in,

    // per-tick result channel
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic       o_scl_out,
    output logic       o_sda_out,
    output logic       o_busy_res,
    output logic       o_done_res,
    output logic [7:0] o_rx_byte,
    output logic       o_ack_seen,
    output logic       o_refused
);

    // ---------------------------------------------------------------
    // Engine state
    // ---------------------------------------------------------------
    logic               r_enabled;
    t_op                r_op,    n_op;
    logic [PHASE_W-1:0] r_phase, n_phase;
    logic [SLOT_W-1:0]  r_slot,  n_slot;   // position inside a three-phase bit slot
    logic [7:0]         r_shift, n_shift;
    logic               r_scl,   n_scl;
    logic               r_sda,   n_sda;
    logic               r_ack,   n_ack;

    // result register
    logic               r_out_valid;
    logic               r_busy,  n_busy;
    logic               r_done,  n_done;
    logic [7:0]         r_rx,    n_rx;
    logic               r_acks,  n_acks;
    logic               r_refused, n_refused;

    logic               in_fire;
    logic               cmd_valid;
    t_op                cur_op;
    logic [PHASE_W-1:0] cur_phase;
    logic [SLOT_W-1:0]  cur_slot;
    logic [7:0]         cur_shift;
    logic               last;

    // Output register frees as its result is taken, so a tick can enter every cycle while results are taken.
    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign in_fire     = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;

    // cmd 0 and cmd 7 fall outside the range and act as plain ticks
    assign cmd_valid = (i_cmd >= 3'(OP_START)) && (i_cmd <= 3'(OP_RACK));

    always_comb begin
        n_op      = r_op;
        n_phase   = r_phase;
        n_slot    = r_slot;
        n_shift   = r_shift;
        n_scl     = r_scl;
        n_sda     = r_sda;
        n_ack     = r_ack;
        n_busy    = 1'b0;
        n_done    = 1'b0;
        n_rx      = 8'd0;
        n_acks    = 1'b0;
        n_refused = 1'b0;

        cur_op    = r_op;
        cur_phase = r_phase;
        cur_slot  = r_slot;
        cur_shift = r_shift;

        // command launch, only from idle
        if (r_op == OP_IDLE && cmd_valid) begin
            if (!r_enabled) begin
                n_refused = 1'b1;
            end else begin
                cur_op    = t_op'(i_cmd);
                cur_phase = '0;
                cur_slot  = SLOT_SDA;
                if (cur_op == OP_SEND) begin
                    cur_shift = i_data_byte;
                end
                if (cur_op == OP_RECV) begin
                    cur_shift = 8'd0;
                end
                if (cur_op == OP_SACK) begin
                    n_ack = i_ack_bit;
                end
            end
        end
        n_shift = cur_shift;

        last = (cur_phase >= last_phase(cur_op));

        if (cur_op != OP_IDLE) begin
            n_busy = 1'b1;
            case (cur_op)
                OP_START: begin
                    case (cur_phase[1:0])
                        2'd0:    n_sda = 1'b1;
                        2'd1:    n_scl = 1'b1;
                        2'd2:    n_sda = 1'b0;
                        default: n_scl = 1'b0;
                    endcase
                end
                OP_STOP: begin
                    case (cur_phase[1:0])
                        2'd0:    n_scl = 1'b0;
                        2'd1:    n_sda = 1'b0;
                        2'd2:    n_scl = 1'b1;
                        default: n_sda = 1'b1;
                    endcase
                end
                OP_SEND: begin
                    // MSB goes out, then the byte moves up for the next slot
                    case (cur_slot)
                        SLOT_SDA: begin
                            n_sda   = cur_shift[7];
                            n_shift = {cur_shift[6:0], 1'b0};
                        end
                        SLOT_HIGH: n_scl = 1'b1;
                        default:   n_scl = 1'b0;
                    endcase
                end
                OP_RECV: begin
                    // phase 0 releases SDA; slots follow from phase 1
                    if (cur_phase == '0) begin
                        n_sda = 1'b1;
                    end else begin
                        case (cur_slot)
                            SLOT_SDA:  n_scl   = 1'b1;
                            SLOT_HIGH: n_shift = {cur_shift[6:0], i_sda_in};
                            default:   n_scl   = 1'b0;
                        endcase
                    end
                end
                OP_SACK: begin
                    case (cur_phase[1:0])
                        2'd0:    n_sda = n_ack;
                        2'd1:    n_scl = 1'b1;
                        default: n_scl = 1'b0;
                    endcase
                end
                default: begin
                    case (cur_phase[1:0])
                        2'd0:    n_sda = 1'b1;
                        2'd1:    n_scl = 1'b1;
                        2'd2:    n_ack = i_sda_in;
                        default: n_scl = 1'b0;
                    endcase
                end
            endcase

            if (last) begin
                n_done  = 1'b1;
                n_op    = OP_IDLE;
                n_phase = '0;
                n_slot  = SLOT_SDA;
                if (cur_op == OP_RECV) begin
                    n_rx = n_shift;
                end
                if (cur_op == OP_RACK) begin
                    n_acks = n_ack;
                end
            end else begin
                n_op    = cur_op;
                n_phase = cur_phase + 1'b1;
                n_slot  = cur_slot;
                // receive holds the slot on its release phase
                if (!(cur_op == OP_RECV && cur_phase == '0)) begin
                    n_slot = (cur_slot == SLOT_LOW) ? SLOT_SDA : cur_slot + 1'b1;
                end
            end
        end
    end

    // control state and line levels
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enabled   <= 1'b0;
            r_op        <= OP_IDLE;
            r_phase     <= '0;
            r_slot      <= SLOT_SDA;
            r_shift     <= 8'd0;
            r_scl       <= 1'b1;
            r_sda       <= 1'b1;
            r_ack       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_enabled <= i_cfg_enabled;
            end
            if (in_fire) begin
                r_op    <= n_op;
                r_phase <= n_phase;
                r_slot  <= n_slot;
                r_shift <= n_shift;
                r_scl   <= n_scl;
                r_sda   <= n_sda;
                r_ack   <= n_ack;
            end
            if (in_fire) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload, loaded with each accepted tick
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_busy    <= n_busy;
            r_done    <= n_done;
            r_rx      <= n_rx;
            r_acks    <= n_acks;
            r_refused <= n_refused;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_scl_out   = r_scl;
    assign o_sda_out   = r_sda;
    assign o_busy_res  = r_busy;
    assign o_done_res  = r_done;
    assign o_rx_byte   = r_rx;
    assign o_ack_seen  = r_acks;
    assign o_refused   = r_refused;

    // ---------------------------------------------------------------
    // Checks
    // ---------------------------------------------------------------
    a_phase_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_op != OP_IDLE |-> r_phase <= last_phase(r_op))
        else $error("phase counter past final phase");

    a_done_idles: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire && n_done |=> r_op == OP_IDLE && r_phase == '0)
        else $error("engine not idle after done");

    a_refuse_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_refused |-> !o_busy_res && !o_done_res)
        else $error("refused tick shows activity");

    a_rx_with_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_rx_byte != 8'd0 || o_ack_seen) |-> o_done_res)
        else $error("receive data outside done");

    a_lines_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire && r_op == OP_IDLE && !(cmd_valid && r_enabled) |=>
            r_scl == $past(r_scl) && r_sda == $past(r_sda))
        else $error("lines moved on an idle tick");

endmodule
